// ----- design/vag_pkg.sv -----
// ----------------------------------------------------------------------------
// vag_pkg: shared types and constants of the VAG ADPCM decoder
// Command beat between front and back end, result status codes and the
// predictor coefficient table.
// ----------------------------------------------------------------------------
`default_nettype none

package vag_pkg;

  // result status codes
  localparam logic [1:0] StatSample = 2'd0;
  localparam logic [1:0] StatFinal  = 2'd1;
  localparam logic [1:0] StatError  = 2'd2;

  // header limits
  localparam logic [3:0] MaxPredictor = 4'd4;
  localparam logic [3:0] MaxShift     = 4'd12;

  // block layout
  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosFlags  = 4'd1;
  localparam logic [3:0] PosLast   = 4'd15;

  // flag codes that end the clip after the block
  localparam logic [7:0] FlagEndBit = 8'h01;
  localparam logic [7:0] FlagEndAlt = 8'h07;

  // default depth of the command queue
  localparam int unsigned QueueDepth = 4;

  // one command from front to back end
  typedef struct packed {
    logic       is_err;  // invalid header: emit error result
    logic [7:0] data;    // two nibbles, low first
    logic [2:0] pred;    // predictor index
    logic [3:0] shift;   // shift amount
    logic       clr;     // clear history before the first nibble
    logic       fin;     // second sample ends the clip
  } vag_cmd_t;

  // coefficient pair of a predictor
  function automatic logic signed [7:0] coef_a(input logic [2:0] pred);
    logic signed [7:0] c;
    case (pred)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [2:0] pred);
    logic signed [7:0] c;
    case (pred)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/vag_if.sv -----
// ----------------------------------------------------------------------------
// vag_if: channel interfaces of the VAG ADPCM decoder
// Byte channel into the decoder and PCM result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface vag_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       clip_start;
  logic       data_end;

  modport source (output valid, data_byte, clip_start, data_end, input ready);
  modport sink   (input valid, data_byte, clip_start, data_end, output ready);
endinterface

interface vag_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, pcm_sample, status, last, input ready);
  modport sink   (input valid, pcm_sample, status, last, output ready);
endinterface

`default_nettype wire

// ----- design/vag_front.sv -----
// ----------------------------------------------------------------------------
// vag_front: block parser
// Tracks the block position, takes header and flag bytes and turns sample
// bytes and bad headers into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  vag_byte_if.sink        byte_i,
  input  wire logic       q_full_i,
  output vag_pkg::vag_cmd_t cmd_o,
  output logic            push_o
);

  logic [3:0] pos_q, pos_d;
  logic [2:0] pred_q, pred_d;
  logic [3:0] shift_q, shift_d;
  logic       eab_q, eab_d;
  logic       stop_q, stop_d;
  logic       clr_q, clr_d;

  logic       take;
  logic [3:0] pos_eff;
  logic       stop_eff;
  logic [3:0] hdr_pred;
  logic [3:0] hdr_shift;
  logic       bad_hdr;
  logic       fin;

  assign byte_i.ready = !q_full_i;
  assign take         = byte_i.valid && byte_i.ready;

  assign pos_eff   = byte_i.clip_start ? vag_pkg::PosHeader : pos_q;
  assign stop_eff  = byte_i.clip_start ? 1'b0 : stop_q;
  assign hdr_pred  = byte_i.data_byte[7:4];
  assign hdr_shift = byte_i.data_byte[3:0];
  assign bad_hdr   = (hdr_pred > vag_pkg::MaxPredictor) || (hdr_shift > vag_pkg::MaxShift);
  // a clip start forces the header position, so the stored flag is enough here
  assign fin       = byte_i.data_end || (pos_eff == vag_pkg::PosLast && eab_q);

  // per-beat parse
  always_comb begin
    pos_d   = pos_q;
    pred_d  = pred_q;
    shift_d = shift_q;
    eab_d   = eab_q;
    stop_d  = stop_q;
    clr_d   = clr_q;
    push_o  = 1'b0;
    cmd_o   = '{is_err: 1'b0, data: byte_i.data_byte, pred: pred_q, shift: shift_q,
                clr: clr_q, fin: 1'b0};
    if (take) begin
      if (byte_i.clip_start) begin
        pos_d  = vag_pkg::PosHeader;
        eab_d  = 1'b0;
        stop_d = 1'b0;
        clr_d  = 1'b1;
      end
      cmd_o.clr = clr_d;
      if (!stop_eff) begin
        if (pos_eff == vag_pkg::PosHeader) begin
          if (bad_hdr) begin
            cmd_o.is_err = 1'b1;
            push_o       = 1'b1;
            stop_d       = 1'b1;
          end else begin
            pred_d  = hdr_pred[2:0];
            shift_d = hdr_shift;
            pos_d   = vag_pkg::PosFlags;
            if (byte_i.data_end) stop_d = 1'b1;
          end
        end else if (pos_eff == vag_pkg::PosFlags) begin
          eab_d = ((byte_i.data_byte & vag_pkg::FlagEndBit) != 8'd0) ||
                  (byte_i.data_byte == vag_pkg::FlagEndAlt);
          pos_d = pos_eff + 4'd1;
          if (byte_i.data_end) stop_d = 1'b1;
        end else begin
          cmd_o.fin = fin;
          push_o    = 1'b1;
          clr_d     = 1'b0;
          pos_d     = pos_eff + 4'd1;
          if (fin) stop_d = 1'b1;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pred_q  <= '0;
      shift_q <= '0;
      eab_q   <= 1'b0;
      stop_q  <= 1'b1;
      clr_q   <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      pred_q  <= pred_d;
      shift_q <= shift_d;
      eab_q   <= eab_d;
      stop_q  <= stop_d;
      clr_q   <= clr_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/vag_queue.sv -----
// ----------------------------------------------------------------------------
// vag_queue: command queue
// Small register FIFO that decouples the parser from the sample decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_queue #(
  parameter int unsigned Depth = vag_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire vag_pkg::vag_cmd_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output vag_pkg::vag_cmd_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vag_pkg::vag_cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  logic do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- design/vag_back.sv -----
// ----------------------------------------------------------------------------
// vag_back: sample decoder
// Decodes one nibble per cycle against the two history samples while pcm_o
// is not stalled, and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire vag_pkg::vag_cmd_t cmd_i,
  output logic                   pop_o,
  vag_pcm_if.source              pcm_o
);

  logic signed [15:0] hist1_q, hist2_q;
  logic               phase_q;
  logic               ovalid_q;
  logic signed [15:0] opcm_q;
  logic [1:0]         ostat_q;
  logic               olast_q;

  logic               go;
  logic [3:0]         nib;
  logic signed [15:0] h1, h2;
  logic signed [15:0] base;
  logic signed [23:0] p1, p2;
  logic signed [25:0] acc;
  logic signed [19:0] pr;
  logic signed [20:0] sum;
  logic signed [15:0] sat;

  assign go    = cmd_valid_i && (!ovalid_q || pcm_o.ready);
  assign pop_o = go && (cmd_i.is_err || phase_q);

  // one sample: scaled nibble plus rounded prediction, saturated
  always_comb begin
    nib  = phase_q ? cmd_i.data[7:4] : cmd_i.data[3:0];
    h1   = (cmd_i.clr && !phase_q) ? 16'sd0 : hist1_q;
    h2   = (cmd_i.clr && !phase_q) ? 16'sd0 : hist2_q;
    base = $signed({nib, 12'd0}) >>> cmd_i.shift;
    p1   = 24'(h1) * 24'(vag_pkg::coef_a(cmd_i.pred));
    p2   = 24'(h2) * 24'(vag_pkg::coef_b(cmd_i.pred));
    acc  = 26'(p1) + 26'(p2) + 26'sd32;
    pr   = 20'(acc >>> 6);
    sum  = 21'(base) + 21'(pr);
    if (sum > 21'sd32767)       sat = 16'sd32767;
    else if (sum < -21'sd32768) sat = -16'sd32768;
    else                        sat = 16'(sum);
  end

  // history and nibble phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q <= '0;
      hist2_q <= '0;
      phase_q <= 1'b0;
    end else if (go && !cmd_i.is_err) begin
      hist1_q <= sat;
      hist2_q <= h1;
      phase_q <= !phase_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (go) begin
      ovalid_q <= 1'b1;
    end else if (pcm_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      if (cmd_i.is_err) begin
        opcm_q  <= '0;
        ostat_q <= vag_pkg::StatError;
        olast_q <= 1'b1;
      end else begin
        opcm_q  <= sat;
        ostat_q <= (phase_q && cmd_i.fin) ? vag_pkg::StatFinal : vag_pkg::StatSample;
        olast_q <= phase_q;
      end
    end
  end

  assign pcm_o.valid      = ovalid_q;
  assign pcm_o.pcm_sample = opcm_q;
  assign pcm_o.status     = ostat_q;
  assign pcm_o.last       = olast_q;

endmodule

`default_nettype wire

// ----- design/vag_adpcm_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// vag_adpcm_decoder_unit: PSX VAG ADPCM decoder
// Feed the ADPCM data area on byte_i, one byte per beat in 16-byte blocks,
// with clip_start on the first byte of a clip and data_end on the last.
// Samples leave on pcm_o, two per sample byte, low nibble first; a bad
// block header gives one error beat (status 2) and stops the clip.
// Header and flag bytes give no beat. A sample byte is decoded one nibble
// at a time by the single multiply-add unit that carries the history from
// one sample to the next. With the queue empty, the first sample of a byte
// passes through the queue and then the output register before it is
// valid on pcm_o.
// The parser runs ahead through a command queue of QueueDepth entries;
// byte_i.ready drops only when that queue is full. When pcm_o stalls, the
// result holds in its output register and the queue fills behind it.
// Reset: history cleared, clip stopped; bytes are ignored until clip_start.
// ----------------------------------------------------------------------------
`default_nettype none

module vag_adpcm_decoder_unit #(
  parameter int unsigned QueueDepth = vag_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vag_byte_if.sink  byte_i,
  vag_pcm_if.source pcm_o
);

  vag_pkg::vag_cmd_t push_cmd, pop_cmd;
  logic              push, q_full, pop, q_valid;

  vag_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .q_full_i(q_full),
    .cmd_o   (push_cmd),
    .push_o  (push)
  );

  vag_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_cmd)
  );

  vag_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .pcm_o      (pcm_o)
  );

endmodule

`default_nettype wire
